FILE: rtl/asp_pkg.sv
// Package for the escape sequence stripper: parse phase type, byte codes
// and the per-byte phase decode. No dependencies.
`default_nettype none

package asp_pkg;

   // Byte codes that steer the parser
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_CSI   = 8'h5B;
   localparam logic [7:0] CH_OSC   = 8'h5D;
   localparam logic [7:0] CH_DCS   = 8'h50;
   localparam logic [7:0] CH_APC   = 8'h5F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] PAR_LO   = 8'h30;
   localparam logic [7:0] PAR_HI   = 8'h3F;
   localparam logic [7:0] INT_LO   = 8'h20;
   localparam logic [7:0] INT_HI   = 8'h2F;
   localparam logic [7:0] FIN_LO   = 8'h40;
   localparam logic [7:0] FIN_HI   = 8'h7E;

   // Parse phase, one-hot
   typedef enum logic [8:0] {
      PH_GROUND   = 9'b0_0000_0001,
      PH_ESC      = 9'b0_0000_0010,
      PH_CSI_PAR  = 9'b0_0000_0100,
      PH_CSI_INT  = 9'b0_0000_1000,
      PH_ONE_MORE = 9'b0_0001_0000,
      PH_OSC      = 9'b0_0010_0000,
      PH_OSC_ESC  = 9'b0_0100_0000,
      PH_STR      = 9'b0_1000_0000,
      PH_STR_ESC  = 9'b1_0000_0000
   } phase_type;

   typedef struct packed {
      logic      keep;
      phase_type next;
   } decode_type;

   // Byte inside a string sequence; bel_ends selects OSC behaviour
   function automatic phase_type string_next(input logic [7:0] b, input logic bel_ends);
      phase_type nxt;
      if (bel_ends && b == CH_BEL) begin
         nxt = PH_GROUND;
      end else if (b == CH_ESC) begin
         nxt = bel_ends ? PH_OSC_ESC : PH_STR_ESC;
      end else begin
         nxt = bel_ends ? PH_OSC : PH_STR;
      end
      return nxt;
   endfunction

   // Judge one byte in the given phase
   function automatic decode_type decode(input phase_type ph, input logic [7:0] b);
      decode_type d;
      logic       is_par;
      logic       is_int;
      logic       is_fin;
      is_par = (b inside {[PAR_LO:PAR_HI]});
      is_int = (b inside {[INT_LO:INT_HI]});
      is_fin = (b inside {[FIN_LO:FIN_HI]});
      d.keep = 1'b0;
      d.next = PH_GROUND;
      case (ph)
         PH_ESC: begin
            if (b == CH_CSI) begin
               d.next = PH_CSI_PAR;
            end else if (b == CH_OSC) begin
               d.next = PH_OSC;
            end else if (b == CH_DCS || b == CH_APC) begin
               d.next = PH_STR;
            end else if (b inside {CH_HASH, CH_LPAR, CH_RPAR}) begin
               d.next = PH_ONE_MORE;
            end else begin
               d.next = PH_GROUND;
            end
         end
         PH_CSI_PAR, PH_CSI_INT: begin
            if (is_par && ph == PH_CSI_PAR) begin
               d.next = PH_CSI_PAR;
            end else if (is_int) begin
               d.next = PH_CSI_INT;
            end else if (is_fin) begin
               d.next = PH_GROUND;
            end else begin
               // sequence broken: byte counts as ground text
               d.keep = (b != CH_ESC);
               d.next = (b == CH_ESC) ? PH_ESC : PH_GROUND;
            end
         end
         PH_ONE_MORE: d.next = PH_GROUND;
         PH_OSC:      d.next = string_next(b, 1'b1);
         PH_OSC_ESC:  d.next = (b == CH_BSL) ? PH_GROUND : string_next(b, 1'b1);
         PH_STR:      d.next = string_next(b, 1'b0);
         PH_STR_ESC:  d.next = (b == CH_BSL) ? PH_GROUND : string_next(b, 1'b0);
         default: begin
            d.keep = (b != CH_ESC);
            d.next = (b == CH_ESC) ? PH_ESC : PH_GROUND;
         end
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ansi_escape_stripper.sv
// Escape sequence stripper top level: phase register and result register.
// Depends on asp_pkg for the phase type and the byte decode.
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | req_in_byte[7:0], req_in_last
//   rsp_     | out       | rsp_valid/rsp_stall  | rsp_keep, rsp_out_byte[7:0], rsp_out_last
//
// One byte per clock while the result is not stalled; the result appears in the cycle after the beat is taken.
// Loops: the phase register feeding the one-level byte decode, and the result valid held while stalled.
// Reset clears the phase to ground and empties the result register.
// A stalled result holds; req_stall rises only while the result register is
// full and stalled, so a new beat enters in the cycle the old one leaves.
`default_nettype none

module ansi_escape_stripper
   import asp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_keep,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);

   phase_type  phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       keep_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       req_take;
   decode_type dec;

   // Stall input only while a result waits and is itself stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   // Decode the incoming byte in the current phase
   always_comb begin
      dec = decode(phase_ff, req_in_byte);
      phase_in = phase_ff;
      if (req_take) begin
         phase_in = req_in_last ? PH_GROUND : dec.next;
      end
      rsp_valid_in = req_take || (rsp_valid_ff && rsp_stall);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_GROUND;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: load on each taken beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         keep_ff <= dec.keep;
         byte_ff <= req_in_byte;
         last_ff <= req_in_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_keep     = keep_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   // The last byte of a text leaves the parser in ground
   a_last_to_ground: assert property (@(posedge clock) disable iff (reset)
      req_take && req_in_last |=> phase_ff == PH_GROUND)
      else $error("phase not ground after last byte");

   // A taken beat always shows as a result next cycle
   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("taken beat produced no result");

   // ESC in ground is dropped and opens a sequence
   a_esc_dropped: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_in_last && phase_ff == PH_GROUND && req_in_byte == CH_ESC
      |=> !rsp_keep && phase_ff == PH_ESC)
      else $error("ESC in ground mishandled");

   // Bytes inside a string are never kept
   a_string_dropped: assert property (@(posedge clock) disable iff (reset)
      req_take && (phase_ff == PH_OSC || phase_ff == PH_STR) |=> !rsp_keep)
      else $error("string byte kept");

endmodule

`default_nettype wire
